@@ hw/rtl/vsp_pkg.sv @@
// Shared types and constants of the 2D velocity step planner.
// Used by vsp_unit, vsp_accel and the top level; depends on nothing.
package vsp_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W = 31;
    localparam int UNIT_IN_W = 36;
    // Cycles of the normalize unit beyond its leading-zero shift stages.
    localparam int UNIT_FIXED_LAT = 68;
    localparam int ACC_LAT = 11;

    typedef enum logic [1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_ACCEL_STEP  = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic               dzero;
        logic               vzero;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } acc_side_t;

    typedef struct packed {
        logic               dzero;
        logic               over;
        logic signed [35:0] nx;
        logic signed [35:0] ny;
    } lim_side_t;

endpackage

@@ hw/rtl/vsp_unit.sv @@
// Pipelined unit-vector unit: leading-zero normalize, square root, two dividers.
// Depends on vsp_pkg for its default widths and latency constant.
module vsp_unit #(
    parameter int IN_W = vsp_pkg::UNIT_IN_W,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] ax,
    input  logic signed [IN_W-1:0] ay,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic signed [31:0]     ux,
    output logic signed [31:0]     uy,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int MW = IN_W - 1;
    localparam int NSH = $clog2(MW);
    localparam int LAT = NSH + vsp_pkg::UNIT_FIXED_LAT;

    logic [MW-1:0]     mgx_reg [NSH+1];
    logic [MW-1:0]     mgy_reg [NSH+1];
    logic [30:0]       m31x;
    logic [30:0]       m31y;
    logic [61:0]       sqx_reg;
    logic [61:0]       sqy_reg;
    logic [30:0]       m1x_reg;
    logic [30:0]       m1y_reg;
    logic [63:0]       rad_reg [33];
    logic [33:0]       rem_reg [33];
    logic [31:0]       root_reg [33];
    logic [30:0]       cx_reg [33];
    logic [30:0]       cy_reg [33];
    logic [61:0]       numx;
    logic [61:0]       numy;
    logic [31:0]       dn_reg [32];
    logic [31:0]       drx_reg [32];
    logic [31:0]       dry_reg [32];
    logic [30:0]       dlx_reg [32];
    logic [30:0]       dly_reg [32];
    logic [30:0]       dqx_reg [32];
    logic [30:0]       dqy_reg [32];
    logic signed [31:0] ux_reg;
    logic signed [31:0] uy_reg;
    logic [LAT-1:0]    vd_reg;
    logic [SIDE_W+1:0] sd_reg [LAT];

    always_ff @(posedge clk)
    begin
        mgx_reg[0] <= MW'(ax[IN_W-1] ? -ax : ax);
        mgy_reg[0] <= MW'(ay[IN_W-1] ? -ay : ay);
    end

    // Shift both magnitudes left together until the larger one is left-aligned.
    for (genvar k = 1; k <= NSH; k++)
    begin : g_norm
        localparam int SH = 2 ** (NSH - k);
        logic [MW-1:0] orv;
        assign orv = mgx_reg[k-1] | mgy_reg[k-1];
        always_ff @(posedge clk)
        begin
            if (orv[MW-1 -: SH] == '0)
            begin
                mgx_reg[k] <= mgx_reg[k-1] << SH;
                mgy_reg[k] <= mgy_reg[k-1] << SH;
            end
            else
            begin
                mgx_reg[k] <= mgx_reg[k-1];
                mgy_reg[k] <= mgy_reg[k-1];
            end
        end
    end

    assign m31x = mgx_reg[NSH][MW-1 -: 31];
    assign m31y = mgy_reg[NSH][MW-1 -: 31];

    always_ff @(posedge clk)
    begin
        sqx_reg <= m31x * m31x;
        sqy_reg <= m31y * m31y;
        m1x_reg <= m31x;
        m1y_reg <= m31y;
        rad_reg[0] <= {1'b0, 63'(sqx_reg) + 63'(sqy_reg)};
        rem_reg[0] <= '0;
        root_reg[0] <= '0;
        cx_reg[0] <= m1x_reg;
        cy_reg[0] <= m1y_reg;
    end

    // Square root, one result bit per stage.
    for (genvar j = 1; j <= 32; j++)
    begin : g_sqrt
        logic [35:0] cand;
        logic [35:0] trial;
        logic        ge;
        assign cand = {rem_reg[j-1], rad_reg[j-1][65-2*j -: 2]};
        assign trial = {2'b00, root_reg[j-1], 2'b01};
        assign ge = cand >= trial;
        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? 34'(cand - trial) : cand[33:0];
            root_reg[j] <= {root_reg[j-1][30:0], ge};
            rad_reg[j] <= rad_reg[j-1];
            cx_reg[j] <= cx_reg[j-1];
            cy_reg[j] <= cy_reg[j-1];
        end
    end

    // Rounded quotient: the numerator carries half the divisor.
    assign numx = 62'({cx_reg[32], 30'b0}) + 62'(root_reg[32][31:1]);
    assign numy = 62'({cy_reg[32], 30'b0}) + 62'(root_reg[32][31:1]);

    always_ff @(posedge clk)
    begin
        dn_reg[0] <= root_reg[32];
        drx_reg[0] <= {1'b0, numx[61:31]};
        dry_reg[0] <= {1'b0, numy[61:31]};
        dlx_reg[0] <= numx[30:0];
        dly_reg[0] <= numy[30:0];
        dqx_reg[0] <= '0;
        dqy_reg[0] <= '0;
    end

    for (genvar i = 1; i <= 31; i++)
    begin : g_div
        logic [32:0] candx;
        logic [32:0] candy;
        logic [32:0] dvs;
        logic        gex;
        logic        gey;
        assign candx = {drx_reg[i-1], dlx_reg[i-1][31-i]};
        assign candy = {dry_reg[i-1], dly_reg[i-1][31-i]};
        assign dvs = {1'b0, dn_reg[i-1]};
        assign gex = candx >= dvs;
        assign gey = candy >= dvs;
        always_ff @(posedge clk)
        begin
            drx_reg[i] <= gex ? 32'(candx - dvs) : candx[31:0];
            dry_reg[i] <= gey ? 32'(candy - dvs) : candy[31:0];
            dqx_reg[i] <= {dqx_reg[i-1][29:0], gex};
            dqy_reg[i] <= {dqy_reg[i-1][29:0], gey};
            dlx_reg[i] <= dlx_reg[i-1];
            dly_reg[i] <= dly_reg[i-1];
            dn_reg[i] <= dn_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg <= sd_reg[LAT-2][SIDE_W] ? -32'(dqx_reg[31]) : 32'(dqx_reg[31]);
        uy_reg <= sd_reg[LAT-2][SIDE_W+1] ? -32'(dqy_reg[31]) : 32'(dqy_reg[31]);
    end

    always_ff @(posedge clk)
    begin
        sd_reg[0] <= {ay[IN_W-1], ax[IN_W-1], side_in};
        for (int s = 1; s < LAT; s++)
        begin
            sd_reg[s] <= sd_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= '0;
        end
        else
        begin
            vd_reg <= {vd_reg[LAT-2:0], in_valid};
        end
    end

    assign out_valid = vd_reg[LAT-1];
    assign ux = ux_reg;
    assign uy = uy_reg;
    assign side_out = sd_reg[LAT-1][SIDE_W-1:0];

endmodule

@@ hw/rtl/vsp_accel.sv @@
// Reflection, acceleration, velocity sum and squared-length test stages.
// Depends on vsp_pkg for the side-band structs and its latency.
module vsp_accel (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [31:0]      ux,
    input  logic signed [31:0]      uy,
    input  logic signed [31:0]      wx,
    input  logic signed [31:0]      wy,
    input  vsp_pkg::acc_side_t      side_in,
    input  logic [30:0]             accel_step,
    input  logic [30:0]             speed_limit,
    output logic                    out_valid,
    output vsp_pkg::lim_side_t      side_out
);

    localparam int NL = vsp_pkg::ACC_LAT;

    logic [NL-1:0]        v_reg;
    vsp_pkg::acc_side_t   sd_reg [NL];
    logic signed [31:0]   u_reg [5][2];
    logic signed [31:0]   w_reg [5][2];
    logic signed [63:0]   p1x_reg, p1y_reg;
    logic signed [64:0]   dot2_reg;
    logic signed [33:0]   t3_reg;
    logic signed [65:0]   q4x_reg, q4y_reg;
    logic signed [33:0]   r5x_reg, r5y_reg;
    logic signed [33:0]   m6x_reg, m6y_reg;
    logic [63:0]          pr7x_reg, pr7y_reg;
    logic                 sg7x_reg, sg7y_reg;
    logic signed [35:0]   a8x_reg, a8y_reg;
    logic signed [35:0]   n9x_reg, n9y_reg;
    logic [69:0]          sq10x_reg, sq10y_reg;
    logic [61:0]          ss10_reg;
    logic signed [35:0]   n10x_reg, n10y_reg;
    vsp_pkg::lim_side_t   out_reg;

    logic [64:0]        dmag;
    logic [35:0]        tm;
    logic [65:0]        qmx, qmy;
    logic [35:0]        rmx, rmy;
    logic [32:0]        mmx, mmy;
    logic [34:0]        amx, amy;
    logic [34:0]        nmx, nmy;

    always_comb
    begin
        dmag = dot2_reg[64] ? 65'(-dot2_reg) : 65'(dot2_reg);
        tm = 36'((dmag + (65'd1 << 28)) >> 29);
        qmx = q4x_reg[65] ? 66'(-q4x_reg) : 66'(q4x_reg);
        qmy = q4y_reg[65] ? 66'(-q4y_reg) : 66'(q4y_reg);
        rmx = 36'((qmx + (66'd1 << 29)) >> 30);
        rmy = 36'((qmy + (66'd1 << 29)) >> 30);
        mmx = 33'(m6x_reg[33] ? -m6x_reg : m6x_reg);
        mmy = 33'(m6y_reg[33] ? -m6y_reg : m6y_reg);
        amx = 35'((pr7x_reg + (64'd1 << 29)) >> 30);
        amy = 35'((pr7y_reg + (64'd1 << 29)) >> 30);
        nmx = 35'(n9x_reg[35] ? -n9x_reg : n9x_reg);
        nmy = 35'(n9y_reg[35] ? -n9y_reg : n9y_reg);
    end

    always_ff @(posedge clk)
    begin
        u_reg[0][0] <= ux;
        u_reg[0][1] <= uy;
        w_reg[0][0] <= wx;
        w_reg[0][1] <= wy;
        for (int s = 1; s < 5; s++)
        begin
            u_reg[s] <= u_reg[s-1];
            w_reg[s] <= w_reg[s-1];
        end
        sd_reg[0] <= side_in;
        for (int s = 1; s < NL; s++)
        begin
            sd_reg[s] <= sd_reg[s-1];
        end

        p1x_reg <= ux * wx;
        p1y_reg <= uy * wy;
        dot2_reg <= 65'(p1x_reg) + 65'(p1y_reg);
        t3_reg <= dot2_reg[64] ? -34'(tm) : 34'(tm);
        q4x_reg <= t3_reg * u_reg[2][0];
        q4y_reg <= t3_reg * u_reg[2][1];
        r5x_reg <= q4x_reg[65] ? -34'(rmx) : 34'(rmx);
        r5y_reg <= q4y_reg[65] ? -34'(rmy) : 34'(rmy);
        // With no current velocity the acceleration points along the direction.
        m6x_reg <= sd_reg[4].vzero ? 34'(u_reg[4][0]) : r5x_reg - 34'(w_reg[4][0]);
        m6y_reg <= sd_reg[4].vzero ? 34'(u_reg[4][1]) : r5y_reg - 34'(w_reg[4][1]);
        pr7x_reg <= mmx * accel_step;
        pr7y_reg <= mmy * accel_step;
        sg7x_reg <= m6x_reg[33];
        sg7y_reg <= m6y_reg[33];
        a8x_reg <= sg7x_reg ? -36'(amx) : 36'(amx);
        a8y_reg <= sg7y_reg ? -36'(amy) : 36'(amy);
        n9x_reg <= 36'(sd_reg[7].vx) + a8x_reg;
        n9y_reg <= 36'(sd_reg[7].vy) + a8y_reg;
        sq10x_reg <= nmx * nmx;
        sq10y_reg <= nmy * nmy;
        ss10_reg <= speed_limit * speed_limit;
        n10x_reg <= n9x_reg;
        n10y_reg <= n9y_reg;
        out_reg.dzero <= sd_reg[9].dzero;
        out_reg.over <= (71'(sq10x_reg) + 71'(sq10y_reg)) > 71'(ss10_reg);
        out_reg.nx <= n10x_reg;
        out_reg.ny <= n10y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NL-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[NL-1];
    assign side_out = out_reg;

endmodule

@@ hw/rtl/velocity_step_planner_2d_top.sv @@
// Top level of the 2D velocity step planner: config registers, input stage,
// three unit-vector pipelines, the acceleration stages and the speed limiter.
// Depends on vsp_pkg, vsp_unit and vsp_accel.

// The planner takes one transaction in every clock cycle: busy is always low,
// and each result appears with done high for one cycle, after its start has
// passed two unit-vector pipelines in series, each with a 32-stage square root
// and 31-stage divider chains, plus 11 acceleration stages and 4 more stages
// for input capture, scaling and saturation.
// Results cannot be held off, so a receiver must take every done pulse.
// Configuration writes are always ready and must only be made while idle.
module velocity_step_planner_2d_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          target_x,
    input  logic signed [31:0]          target_y,
    input  logic signed [31:0]          position_x,
    input  logic signed [31:0]          position_y,
    input  logic signed [31:0]          velocity_x,
    input  logic signed [31:0]          velocity_y,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [vsp_pkg::CFG_W-1:0]   cfg_data,
    output logic                        done,
    output logic signed [31:0]          next_velocity_x,
    output logic signed [31:0]          next_velocity_y,
    output logic                        moving
);

    localparam int UW = vsp_pkg::UNIT_IN_W;
    localparam int ULAT = $clog2(UW - 1) + vsp_pkg::UNIT_FIXED_LAT;
    localparam int PIPE_LAT = 2 * ULAT + vsp_pkg::ACC_LAT + 4;
    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (vsp_pkg::WORD_W - 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -(36'sd1 <<< (vsp_pkg::WORD_W - 1));

    logic [vsp_pkg::CFG_W-1:0] speed_reg;
    logic [vsp_pkg::CFG_W-1:0] accel_reg;

    logic                  in_v_reg;
    logic signed [32:0]    dx_reg, dy_reg;
    logic signed [31:0]    vx_reg, vy_reg;
    vsp_pkg::acc_side_t    d_side;
    logic                  vzero;

    logic                  u_valid, w_valid, a_valid, p_valid;
    logic signed [31:0]    u_x, u_y, w_x, w_y, p_x, p_y;
    vsp_pkg::acc_side_t    u_side;
    logic                  w_side;
    vsp_pkg::lim_side_t    a_side, p_side;

    logic                  f1_v_reg, f2_v_reg, done_reg;
    logic [61:0]           f1px_reg, f1py_reg;
    logic                  f1sx_reg, f1sy_reg;
    vsp_pkg::lim_side_t    f1_side_reg, f2_side_reg;
    logic signed [33:0]    f2x_reg, f2y_reg;
    logic signed [31:0]    nvx_reg, nvy_reg;
    logic                  mov_reg;

    logic [30:0]           pmx, pmy;
    logic [32:0]           scmx, scmy;
    logic signed [35:0]    selx, sely;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            accel_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vsp_pkg::CFG_SPEED_LIMIT: speed_reg <= cfg_data;
                vsp_pkg::CFG_ACCEL_STEP:  accel_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        dx_reg <= 33'(target_x) - 33'(position_x);
        dy_reg <= 33'(target_y) - 33'(position_y);
        vx_reg <= velocity_x;
        vy_reg <= velocity_y;
    end

    assign vzero = (vx_reg == '0) && (vy_reg == '0);
    assign d_side.dzero = (dx_reg == '0) && (dy_reg == '0);
    assign d_side.vzero = vzero;
    assign d_side.vx = vx_reg;
    assign d_side.vy = vy_reg;

    vsp_unit #(.IN_W(UW), .SIDE_W($bits(vsp_pkg::acc_side_t))) u_unit_d (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg),
        .ax(UW'(dx_reg)), .ay(UW'(dy_reg)), .side_in(d_side),
        .out_valid(u_valid), .ux(u_x), .uy(u_y), .side_out(u_side)
    );

    vsp_unit #(.IN_W(UW), .SIDE_W(1)) u_unit_v (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg),
        .ax(UW'(vx_reg)), .ay(UW'(vy_reg)), .side_in(vzero),
        .out_valid(w_valid), .ux(w_x), .uy(w_y), .side_out(w_side)
    );

    vsp_accel u_accel (
        .clk(clk), .rst_n(rst_n), .in_valid(u_valid),
        .ux(u_x), .uy(u_y), .wx(w_x), .wy(w_y), .side_in(u_side),
        .accel_step(accel_reg), .speed_limit(speed_reg),
        .out_valid(a_valid), .side_out(a_side)
    );

    vsp_unit #(.IN_W(UW), .SIDE_W($bits(vsp_pkg::lim_side_t))) u_unit_n (
        .clk(clk), .rst_n(rst_n), .in_valid(a_valid),
        .ax(a_side.nx), .ay(a_side.ny), .side_in(a_side),
        .out_valid(p_valid), .ux(p_x), .uy(p_y), .side_out(p_side)
    );

    always_comb
    begin
        pmx = 31'(p_x[31] ? -p_x : p_x);
        pmy = 31'(p_y[31] ? -p_y : p_y);
        scmx = 33'((63'(f1px_reg) + (63'd1 << 29)) >> 30);
        scmy = 33'((63'(f1py_reg) + (63'd1 << 29)) >> 30);
        selx = f2_side_reg.over ? 36'(f2x_reg) : f2_side_reg.nx;
        sely = f2_side_reg.over ? 36'(f2y_reg) : f2_side_reg.ny;
    end

    always_ff @(posedge clk)
    begin
        f1px_reg <= pmx * speed_reg;
        f1py_reg <= pmy * speed_reg;
        f1sx_reg <= p_x[31];
        f1sy_reg <= p_y[31];
        f1_side_reg <= p_side;
        f2x_reg <= f1sx_reg ? -34'(scmx) : 34'(scmx);
        f2y_reg <= f1sy_reg ? -34'(scmy) : 34'(scmy);
        f2_side_reg <= f1_side_reg;
        if (f2_side_reg.dzero)
        begin
            nvx_reg <= '0;
            nvy_reg <= '0;
        end
        else
        begin
            nvx_reg <= (selx > SAT_HI) ? 32'(SAT_HI) : ((selx < SAT_LO) ? 32'(SAT_LO) : 32'(selx));
            nvy_reg <= (sely > SAT_HI) ? 32'(SAT_HI) : ((sely < SAT_LO) ? 32'(SAT_LO) : 32'(sely));
        end
        mov_reg <= !f2_side_reg.dzero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
            f1_v_reg <= p_valid;
            f2_v_reg <= f1_v_reg;
            done_reg <= f2_v_reg;
        end
    end

    assign done = done_reg;
    assign next_velocity_x = nvx_reg;
    assign next_velocity_y = nvy_reg;
    assign moving = mov_reg;

    // The two unit pipelines run in lockstep and their side bands stay aligned.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (u_valid == w_valid) && (!u_valid || (w_side == u_side.vzero)))
        else $error("direction and velocity unit pipelines out of step");

    // Every accepted transaction yields its result a fixed latency later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("result strobe missing at pipeline latency");

endmodule
